// ===== sv/rbef_pkg.sv =====
`timescale 1ns / 1ps
package rbef_pkg;
  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned FRAC_OUT_W = 16;

  typedef logic signed [FIELD_W-1:0]  coord_field_t;
  typedef logic        [FRAC_OUT_W-1:0] frac_field_t;
endpackage

// ===== sv/rbef_ifs.sv =====
`timescale 1ns / 1ps
interface rbef_in_if;
  import rbef_pkg::*;
  logic         valid;
  logic         ready;
  coord_field_t seg_start_x;
  coord_field_t seg_start_y;
  coord_field_t seg_end_x;
  coord_field_t seg_end_y;
  coord_field_t box_min_x;
  coord_field_t box_min_y;
  coord_field_t box_max_x;
  coord_field_t box_max_y;

  modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  box_min_x, box_min_y, box_max_x, box_max_y, input ready);
  modport sink   (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  box_min_x, box_min_y, box_max_x, box_max_y, output ready);
endinterface

interface rbef_out_if;
  import rbef_pkg::*;
  logic        valid;
  logic        ready;
  logic        hit;
  frac_field_t entry_fraction;

  modport source (output valid, hit, entry_fraction, input ready);
  modport sink   (input valid, hit, entry_fraction, output ready);
endinterface

// ===== sv/ray_box_entry_fraction.sv =====
`timescale 1ns / 1ps
// channel | dir | handshake        | payload
// in_ch   | in  | valid/ready      | segment start/end, box min/max (Q16.16)
// out_ch  | out | valid/ready      | hit, entry_fraction (Q0.16)
//
// One transfer per cycle in, one per cycle out, while out_ch is not stalled.
// Latency is set by the divider, one quotient bit per stage, plus setup,
// multiply, compare and merge stages.
// Reset clears only the valid bits of the pipeline.
// A stall at out_ch freezes the whole pipeline; in_ch.ready drops with it.
module ray_box_entry_fraction #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  rbef_in_if.sink     in_ch,
  rbef_out_if.source  out_ch
);
  import rbef_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRACTION_BITS;
  localparam int LAT = F + 4;

  logic                en;
  logic [LAT-1:0]      v_r;
  logic signed [W-1:0] sx, sy, ex, ey, nx, ny, xx, xy;
  logic                hx, hy;
  logic [F-1:0]        ux, uy, res;
  logic [F+FRAC_OUT_W-1:0] res_ext;
  logic                hit_r;
  frac_field_t         frac_r;

  assign en          = !v_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  assign sx = W'(in_ch.seg_start_x);
  assign sy = W'(in_ch.seg_start_y);
  assign ex = W'(in_ch.seg_end_x);
  assign ey = W'(in_ch.seg_end_y);
  assign nx = W'(in_ch.box_min_x);
  assign ny = W'(in_ch.box_min_y);
  assign xx = W'(in_ch.box_max_x);
  assign xy = W'(in_ch.box_max_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_ch.valid};
    end
  end

  rbef_axis #(.W(W), .F(F)) u_axis_x (
    .clk, .en,
    .a_start(sx), .a_end(ex), .a_min(nx), .a_max(xx),
    .b_start(sy), .b_end(ey), .b_min(ny), .b_max(xy),
    .hit(hx), .frac(ux)
  );

  rbef_axis #(.W(W), .F(F)) u_axis_y (
    .clk, .en,
    .a_start(sy), .a_end(ey), .a_min(ny), .a_max(xy),
    .b_start(sx), .b_end(ex), .b_min(nx), .b_max(xx),
    .hit(hy), .frac(uy)
  );

  always_comb begin
    priority if (hx && hy) begin
      res = (ux < uy) ? ux : uy;
    end else if (hx) begin
      res = ux;
    end else begin
      res = uy;
    end
    res_ext = (F+FRAC_OUT_W)'(res);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= hx || hy;
      frac_r <= (hx || hy) ? res_ext[FRAC_OUT_W-1:0] : '0;
    end
  end

  assign out_ch.valid          = v_r[LAT-1];
  assign out_ch.hit            = hit_r;
  assign out_ch.entry_fraction = frac_r;
endmodule

// ===== sv/rbef_axis.sv =====
`timescale 1ns / 1ps
module rbef_axis #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] a_start,
  input  logic signed [W-1:0] a_end,
  input  logic signed [W-1:0] a_min,
  input  logic signed [W-1:0] a_max,
  input  logic signed [W-1:0] b_start,
  input  logic signed [W-1:0] b_end,
  input  logic signed [W-1:0] b_min,
  input  logic signed [W-1:0] b_max,
  output logic                hit,
  output logic [F-1:0]        frac
);
  localparam int DW = W + 1;
  localparam int EW = W + 2;

  logic signed [DW-1:0] as_e, ae_e, amin_e, amax_e, d;
  logic                 low, high;
  logic [DW-1:0]        num_nxt, den_nxt, mag_nxt;

  logic                face_r [0:F];
  logic [DW-1:0]       r_r    [0:F];
  logic [DW-1:0]       den_r  [0:F];
  logic [F-1:0]        q_r    [0:F];
  logic                neg_r  [0:F];
  logic [DW-1:0]       mag_r  [0:F];
  logic signed [W-1:0] bs_r   [0:F];
  logic signed [W-1:0] bmin_r [0:F];
  logic signed [W-1:0] bmax_r [0:F];

  logic                face_m_r, neg_m_r;
  logic [DW-1:0]       off_r;
  logic [F-1:0]        q_m_r;
  logic signed [W-1:0] bs_m_r, bmin_m_r, bmax_m_r;
  logic [F+DW-1:0]     prod;
  logic signed [EW-1:0] offs, b;
  logic                hit_r;
  logic [F-1:0]        frac_r;

  always_comb begin
    as_e    = DW'(a_start);
    ae_e    = DW'(a_end);
    amin_e  = DW'(a_min);
    amax_e  = DW'(a_max);
    low     = (as_e < amin_e) && (ae_e > amin_e);
    high    = (as_e > amax_e) && (ae_e < amax_e);
    num_nxt = low ? DW'(amin_e - as_e) : DW'(as_e - amax_e);
    den_nxt = low ? DW'(ae_e - as_e)   : DW'(as_e - ae_e);
    d       = DW'(b_end) - DW'(b_start);
    mag_nxt = d[DW-1] ? DW'(-d) : DW'(d);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      face_r[0] <= low || high;
      r_r[0]    <= num_nxt;
      den_r[0]  <= den_nxt;
      q_r[0]    <= '0;
      neg_r[0]  <= d[DW-1];
      mag_r[0]  <= mag_nxt;
      bs_r[0]   <= b_start;
      bmin_r[0] <= b_min;
      bmax_r[0] <= b_max;
    end
  end

  // one quotient bit per stage, restoring
  for (genvar i = 0; i < F; i++) begin : g_div
    logic [DW:0] sh;
    logic        ge;
    always_comb begin
      sh = {r_r[i], 1'b0};
      ge = sh >= {1'b0, den_r[i]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        face_r[i+1] <= face_r[i];
        r_r[i+1]    <= ge ? DW'(sh - {1'b0, den_r[i]}) : DW'(sh);
        den_r[i+1]  <= den_r[i];
        q_r[i+1]    <= {q_r[i][F-2:0], ge};
        neg_r[i+1]  <= neg_r[i];
        mag_r[i+1]  <= mag_r[i];
        bs_r[i+1]   <= bs_r[i];
        bmin_r[i+1] <= bmin_r[i];
        bmax_r[i+1] <= bmax_r[i];
      end
    end
  end

  assign prod = (F+DW)'(q_r[F]) * (F+DW)'(mag_r[F]);

  always_ff @(posedge clk) begin
    if (en) begin
      face_m_r <= face_r[F];
      neg_m_r  <= neg_r[F];
      off_r    <= prod[F+DW-1:F];
      q_m_r    <= q_r[F];
      bs_m_r   <= bs_r[F];
      bmin_m_r <= bmin_r[F];
      bmax_m_r <= bmax_r[F];
    end
  end

  always_comb begin
    offs = signed'(EW'(off_r));
    b    = neg_m_r ? (EW'(bs_m_r) - offs) : (EW'(bs_m_r) + offs);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= face_m_r && (b > EW'(bmin_m_r)) && (b < EW'(bmax_m_r));
      frac_r <= q_m_r;
    end
  end

  assign hit  = hit_r;
  assign frac = frac_r;
endmodule

// ===== sv/rbef_check.sv =====
`timescale 1ns / 1ps
module rbef_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_hit,
  input logic [15:0] out_frac
);
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_frac == 16'd0)
    else $error("miss with nonzero fraction");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_frac))
    else $error("stalled result changed");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");
endmodule

bind ray_box_entry_fraction rbef_check u_rbef_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_hit   (out_ch.hit),
  .out_frac  (out_ch.entry_fraction)
);
